FILE: design/stl_pkg.sv
`default_nettype none

package stl_pkg;

    // queue depths, powers of two
    localparam int FRONT_DEPTH = 2;
    localparam int OUT_DEPTH   = 4;
    localparam int FPTR_W      = $clog2(FRONT_DEPTH);
    localparam int FCNT_W      = $clog2(FRONT_DEPTH + 1);
    localparam int OPTR_W      = $clog2(OUT_DEPTH);
    localparam int OCNT_W      = $clog2(OUT_DEPTH + 1);

    // token kinds
    localparam logic [4:0] K_ENDFILE = 5'd0;
    localparam logic [4:0] K_NEWLINE = 5'd1;
    localparam logic [4:0] K_SEMI    = 5'd2;
    localparam logic [4:0] K_STR     = 5'd3;
    localparam logic [4:0] K_CMD     = 5'd4;
    localparam logic [4:0] K_AND     = 5'd5;
    localparam logic [4:0] K_OR      = 5'd6;
    localparam logic [4:0] K_PIPE    = 5'd7;
    localparam logic [4:0] K_NOT     = 5'd8;
    localparam logic [4:0] K_LPAREN  = 5'd9;
    localparam logic [4:0] K_RPAREN  = 5'd10;
    localparam logic [4:0] K_IN      = 5'd11;
    localparam logic [4:0] K_OUT     = 5'd12;
    localparam logic [4:0] K_APPEND  = 5'd13;
    localparam logic [4:0] K_MOUT    = 5'd14;
    localparam logic [4:0] K_MAPPEND = 5'd15;
    localparam logic [4:0] K_MSTREAM = 5'd16;

    // error codes
    localparam logic [2:0] E_NONE      = 3'd0;
    localparam logic [2:0] E_FORBIDDEN = 3'd1;
    localparam logic [2:0] E_UNTERM    = 3'd2;
    localparam logic [2:0] E_BAD_AMP   = 3'd3;
    localparam logic [2:0] E_EMPTY_CMD = 3'd4;

    // character classes seen by the lexer
    typedef enum logic [4:0] {
        CC_OTHER,
        CC_SPACE,     // whitespace other than newline
        CC_NEWLINE,
        CC_NUL,
        CC_DIGIT,
        CC_SEMI,
        CC_DQUOTE,
        CC_HASH,
        CC_AMP,
        CC_PIPE,
        CC_LT,
        CC_BANG,
        CC_GT,
        CC_LPAREN,
        CC_RPAREN,
        CC_FORBID,    // single quote, colon, caret, percent
        CC_EOF
    } char_class_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eof;
        char_class_t cls;
    } cls_item_t;

    typedef struct packed {
        logic      valid;
        cls_item_t item;
    } front_link_t;

    typedef struct packed {
        logic       keep_char;
        logic [7:0] text_char;
        logic       token_done;
        logic [4:0] token_kind;
        logic [2:0] error_code;
        logic       last;
    } result_t;

    function automatic char_class_t classify(input logic [7:0] c);
        char_class_t r;
        r = CC_OTHER;
        case (c)
            8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d: r = CC_SPACE;
            8'h0a: r = CC_NEWLINE;
            8'h00: r = CC_NUL;
            8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
            8'h35, 8'h36, 8'h37, 8'h38, 8'h39: r = CC_DIGIT;
            8'h3b: r = CC_SEMI;
            8'h22: r = CC_DQUOTE;
            8'h23: r = CC_HASH;
            8'h26: r = CC_AMP;
            8'h7c: r = CC_PIPE;
            8'h3c: r = CC_LT;
            8'h21: r = CC_BANG;
            8'h3e: r = CC_GT;
            8'h28: r = CC_LPAREN;
            8'h29: r = CC_RPAREN;
            8'h27, 8'h3a, 8'h5e, 8'h25: r = CC_FORBID;
            default: r = CC_OTHER;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: design/stl_front.sv
`default_nettype none

module stl_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic [7:0]         ch,
    input  wire logic               end_of_input,
    output stl_pkg::front_link_t    link,
    input  wire logic               take
);
    import stl_pkg::*;

    cls_item_t           q_reg [FRONT_DEPTH];
    logic [FPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]   count_reg, count_next;
    cls_item_t           new_item;
    logic                do_push;
    logic                do_take;

    // classify on the way in; eof carries a zero byte
    always_comb
    begin
        new_item.eof = end_of_input;
        new_item.ch  = end_of_input ? 8'h00 : ch;
        new_item.cls = end_of_input ? CC_EOF : classify(ch);
    end

    assign full    = (count_reg == FCNT_W'(FRONT_DEPTH));
    assign do_push = push && !full;
    assign do_take = take && (count_reg != '0);

    assign link.valid = (count_reg != '0);
    assign link.item  = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_take ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/stl_back.sv
`default_nettype none

module stl_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire stl_pkg::front_link_t link,
    output logic                      take,
    input  wire logic                 space,
    output logic                      res_push,
    output stl_pkg::result_t          res
);
    import stl_pkg::*;

    typedef enum logic [3:0] {
        ST_START,
        ST_COMMENT,
        ST_CMD,
        ST_DIGIT,
        ST_STR,
        ST_AND,
        ST_MEGOUT,
        ST_MEGSTRM,
        ST_PIPE,
        ST_RARR
    } lex_state_t;

    lex_state_t   state_reg, state_next;
    logic         nonempty_reg, nonempty_next;
    logic [1:0]   pass_reg, pass_next;

    lex_state_t   nxt;
    logic         keep, consume, done, fin, fire, cmd_term, is_eof;
    logic [4:0]   kind;
    logic [2:0]   err;
    char_class_t  cls;

    assign cls    = link.item.cls;
    assign is_eof = link.item.eof;

    // characters that end a command word
    always_comb
    begin
        case (cls)
            CC_EOF, CC_SPACE, CC_NEWLINE, CC_FORBID, CC_AMP, CC_PIPE, CC_BANG,
            CC_LT, CC_GT, CC_DQUOTE, CC_SEMI, CC_LPAREN, CC_RPAREN, CC_HASH:
                cmd_term = 1'b1;
            default:
                cmd_term = 1'b0;
        endcase
    end

    // one lexer pass over the head character
    always_comb
    begin
        keep    = !is_eof;
        consume = 1'b1;
        done    = 1'b0;
        kind    = K_ENDFILE;
        err     = E_NONE;
        nxt     = state_reg;
        case (state_reg)
            ST_START:
            begin
                case (cls)
                    CC_EOF:     begin keep = 1'b0; done = 1'b1; kind = K_ENDFILE; end
                    CC_SPACE:   keep = 1'b0;
                    CC_DIGIT:   nxt = ST_DIGIT;
                    CC_NUL,
                    CC_NEWLINE: begin done = 1'b1; kind = K_NEWLINE; end
                    CC_SEMI:    begin done = 1'b1; kind = K_SEMI; end
                    CC_DQUOTE:  begin keep = 1'b0; nxt = ST_STR; end
                    CC_HASH:    begin keep = 1'b0; nxt = ST_COMMENT; end
                    CC_AMP:     nxt = ST_AND;
                    CC_PIPE:    nxt = ST_PIPE;
                    CC_LT:      begin done = 1'b1; kind = K_IN; end
                    CC_BANG:    begin done = 1'b1; kind = K_NOT; end
                    CC_GT:      nxt = ST_RARR;
                    CC_LPAREN:  begin done = 1'b1; kind = K_LPAREN; end
                    CC_RPAREN:  begin done = 1'b1; kind = K_RPAREN; end
                    CC_FORBID:  err = E_FORBIDDEN;
                    default:    nxt = ST_CMD;
                endcase
            end
            ST_COMMENT:
            begin
                keep = 1'b0;
                if (cls == CC_EOF)
                begin
                    done = 1'b1;
                    kind = K_ENDFILE;
                end
                else if (cls == CC_NEWLINE)
                begin
                    done = 1'b1;
                    kind = K_NEWLINE;
                end
            end
            ST_CMD:
            begin
                if (cmd_term)
                begin
                    if (!nonempty_reg)
                    begin
                        err = E_EMPTY_CMD;
                    end
                    else
                    begin
                        done    = 1'b1;
                        kind    = K_CMD;
                        keep    = 1'b0;
                        consume = 1'b0;
                    end
                end
            end
            ST_DIGIT:
            begin
                if (cls == CC_GT)
                begin
                    nxt = ST_RARR;
                end
                else if (cls != CC_DIGIT)
                begin
                    keep    = 1'b0;
                    consume = 1'b0;
                    nxt     = ST_CMD;
                end
            end
            ST_STR:
            begin
                if (cls == CC_EOF || cls == CC_NEWLINE)
                begin
                    err = E_UNTERM;
                end
                else if (cls == CC_DQUOTE)
                begin
                    keep = 1'b0;
                    done = 1'b1;
                    kind = K_STR;
                end
            end
            ST_AND:
            begin
                if (cls == CC_AMP)
                begin
                    done = 1'b1;
                    kind = K_AND;
                end
                else if (cls == CC_GT)
                begin
                    nxt = ST_MEGOUT;
                end
                else
                begin
                    err = E_BAD_AMP;
                end
            end
            ST_MEGOUT:
            begin
                done = 1'b1;
                if (cls == CC_GT)
                begin
                    kind = K_MAPPEND;
                end
                else
                begin
                    kind    = K_MOUT;
                    keep    = 1'b0;
                    consume = 1'b0;
                end
            end
            ST_MEGSTRM:
            begin
                if (cls != CC_DIGIT)
                begin
                    done    = 1'b1;
                    kind    = K_MSTREAM;
                    keep    = 1'b0;
                    consume = 1'b0;
                end
            end
            ST_PIPE:
            begin
                done = 1'b1;
                if (cls == CC_PIPE)
                begin
                    kind = K_OR;
                end
                else
                begin
                    kind    = K_PIPE;
                    keep    = 1'b0;
                    consume = 1'b0;
                end
            end
            ST_RARR:
            begin
                if (cls == CC_AMP)
                begin
                    nxt = ST_MEGSTRM;
                end
                else if (cls == CC_GT)
                begin
                    done = 1'b1;
                    kind = K_APPEND;
                end
                else
                begin
                    done    = 1'b1;
                    kind    = K_OUT;
                    keep    = 1'b0;
                    consume = 1'b0;
                end
            end
            default:
            begin
                keep = 1'b0;
                nxt  = ST_START;
            end
        endcase

        // errors drop the character and reset the lexer
        if (err != E_NONE)
        begin
            keep    = 1'b0;
            done    = 1'b0;
            kind    = K_ENDFILE;
            consume = 1'b1;
        end
    end

    assign fin      = consume || (pass_reg == 2'd2);
    assign fire     = link.valid && space;
    assign take     = fire && fin;
    assign res_push = fire;

    always_comb
    begin
        res.keep_char  = keep;
        res.text_char  = link.item.ch;
        res.token_done = done;
        res.token_kind = kind;
        res.error_code = err;
        res.last       = fin;
    end

    always_comb
    begin
        state_next    = state_reg;
        nonempty_next = nonempty_reg;
        pass_next     = pass_reg;
        if (fire)
        begin
            pass_next = fin ? 2'd0 : pass_reg + 2'd1;
            if (err != E_NONE || done)
            begin
                state_next    = ST_START;
                nonempty_next = 1'b0;
            end
            else
            begin
                state_next    = nxt;
                nonempty_next = nonempty_reg | keep;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_START;
            nonempty_reg <= 1'b0;
            pass_reg     <= 2'd0;
        end
        else
        begin
            state_reg    <= state_next;
            nonempty_reg <= nonempty_next;
            pass_reg     <= pass_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/stl_outq.sv
`default_nettype none

module stl_outq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire stl_pkg::result_t wr_data,
    output logic                  space,
    output logic                  empty,
    input  wire logic             pop,
    output stl_pkg::result_t      head
);
    import stl_pkg::*;

    result_t             q_reg [OUT_DEPTH];
    logic [OPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OCNT_W-1:0]   count_reg, count_next;
    logic                do_pop;

    assign space  = (count_reg != OCNT_W'(OUT_DEPTH));
    assign empty  = (count_reg == '0);
    assign do_pop = pop && !empty;
    assign head   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!wr_en && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            q_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/shell_token_lexer.sv
// a character's first result passes through the input queue and then the result queue before
//   it shows on the result ports and can be popped
// the lexer makes one pass per cycle while the result queue has room, and a character needs
//   one to three passes; the input queue can take the next character while the lexer works
// on the head; the 2-entry input queue raises full when the lexer or the 4-entry result queue stalls
// reset: rst_n async active low, clears queues, lexer returns to start with empty token text
`default_nettype none

module shell_token_lexer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input side, queue style
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  ch,
    input  wire logic        end_of_input,
    // result side, queue style
    output logic             empty,
    input  wire logic        pop,
    output logic             keep_char,
    output logic [7:0]       text_char,
    output logic             token_done,
    output logic [4:0]       token_kind,
    output logic [2:0]       error_code,
    output logic             last
);
    import stl_pkg::*;

    front_link_t  link;
    logic         take;
    logic         space;
    logic         res_push;
    result_t      res;
    result_t      head;

    // front: classify each character and hold it until the lexer takes it
    stl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .ch           (ch),
        .end_of_input (end_of_input),
        .link         (link),
        .take         (take)
    );

    // back: one pass per cycle while the result queue has room; the head leaves on its last pass
    stl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .link     (link),
        .take     (take),
        .space    (space),
        .res_push (res_push),
        .res      (res)
    );

    // result queue decouples the lexer from the consumer
    stl_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res),
        .space   (space),
        .empty   (empty),
        .pop     (pop),
        .head    (head)
    );

    // result ports show the oldest waiting result
    assign keep_char  = head.keep_char;
    assign text_char  = head.text_char;
    assign token_done = head.token_done;
    assign token_kind = head.token_kind;
    assign error_code = head.error_code;
    assign last       = head.last;

endmodule

`default_nettype wire

FILE: design/stl_checker.sv
`default_nettype none

module stl_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic       keep_char,
    input  wire logic [7:0] text_char,
    input  wire logic       token_done,
    input  wire logic [4:0] token_kind,
    input  wire logic [2:0] error_code,
    input  wire logic       last
);
    import stl_pkg::*;

    // a waiting result stays until its transfer
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("result withdrawn before transfer");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(text_char) && $stable(token_kind) && $stable(last))
        else $error("waiting result changed");

    // an error result drops the character and closes the input's results
    a_err_pass: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && error_code != E_NONE |-> last && !keep_char && !token_done)
        else $error("error result not final or keeps text");

    // a finished token never carries an error
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && token_done |-> error_code == E_NONE)
        else $error("token end with error code");

endmodule

bind shell_token_lexer stl_checker u_stl_checker (.*);

`default_nettype wire

FILE: test/token_lexer_checker.sv
module token_lexer_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire logic       full,
    input  wire logic [7:0] ch,
    input  wire logic       end_of_input,
    input  wire logic       empty,
    input  wire logic       pop,
    input  wire logic       keep_char,
    input  wire logic [7:0] text_char,
    input  wire logic       token_done,
    input  wire logic [4:0] token_kind,
    input  wire logic [2:0] error_code,
    input  wire logic       last,
    output int              mismatch_count,
    output int              passes_outstanding
);
    import stl_pkg::*;

    typedef enum logic [3:0] {
        LX_START,
        LX_COMMENT,
        LX_WORD,
        LX_DIGIT,
        LX_STRING,
        LX_AMP,
        LX_AMP_GT,
        LX_GT_AMP,
        LX_BAR,
        LX_GT
    } lex_state_t;

    lex_state_t lex_state     = LX_START;
    logic       word_nonempty = 1'b0;
    result_t    expected_passes[$];

    function automatic logic is_blank(input logic [7:0] c);
        return c == " " || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic logic is_digit_char(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // bytes that end a command word
    function automatic logic is_word_break(input logic [7:0] c);
        case (c)
            "&", "|", "!", "<", ">", "\"", "'", ";", ":", "(", ")", "^", "%", "#":
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

    // bytes that may not open a token
    function automatic logic is_forbidden(input logic [7:0] c);
        return c == "'" || c == ":" || c == "^" || c == "%";
    endfunction

    // one to three lexer passes per accepted character
    task automatic lex_one_input(input logic [7:0] raw_ch, input logic eof);
        logic [7:0] c;
        int         n;
        logic       fin;
        logic       keep;
        logic       consume;
        logic       done;
        logic [4:0] kind;
        logic [2:0] err;
        lex_state_t nxt;
        result_t    r;
        c   = eof ? 8'h00 : raw_ch;
        n   = 0;
        fin = 1'b0;
        while (!fin)
        begin
            keep    = !eof;
            consume = 1'b1;
            done    = 1'b0;
            kind    = K_ENDFILE;
            err     = E_NONE;
            nxt     = lex_state;
            case (lex_state)
                LX_COMMENT:
                begin
                    keep = 1'b0;
                    if (eof)
                    begin
                        done = 1'b1;
                        kind = K_ENDFILE;
                    end
                    else if (c == 8'h0a)
                    begin
                        done = 1'b1;
                        kind = K_NEWLINE;
                    end
                end
                LX_WORD:
                begin
                    if (eof || is_blank(c) || is_word_break(c))
                    begin
                        if (!word_nonempty)
                            err = E_EMPTY_CMD;
                        else
                        begin
                            done    = 1'b1;
                            kind    = K_CMD;
                            keep    = 1'b0;
                            consume = 1'b0;
                        end
                    end
                end
                LX_DIGIT:
                begin
                    if (!eof && c == ">")
                        nxt = LX_GT;
                    else if (eof || !is_digit_char(c))
                    begin
                        keep    = 1'b0;
                        consume = 1'b0;
                        nxt     = LX_WORD;
                    end
                end
                LX_STRING:
                begin
                    if (eof || c == 8'h0a)
                        err = E_UNTERM;
                    else if (c == "\"")
                    begin
                        keep = 1'b0;
                        done = 1'b1;
                        kind = K_STR;
                    end
                end
                LX_AMP:
                begin
                    if (!eof && c == "&")
                    begin
                        done = 1'b1;
                        kind = K_AND;
                    end
                    else if (!eof && c == ">")
                        nxt = LX_AMP_GT;
                    else
                        err = E_BAD_AMP;
                end
                LX_AMP_GT:
                begin
                    done = 1'b1;
                    if (!eof && c == ">")
                        kind = K_MAPPEND;
                    else
                    begin
                        kind    = K_MOUT;
                        keep    = 1'b0;
                        consume = 1'b0;
                    end
                end
                LX_GT_AMP:
                begin
                    if (eof || !is_digit_char(c))
                    begin
                        done    = 1'b1;
                        kind    = K_MSTREAM;
                        keep    = 1'b0;
                        consume = 1'b0;
                    end
                end
                LX_BAR:
                begin
                    done = 1'b1;
                    if (!eof && c == "|")
                        kind = K_OR;
                    else
                    begin
                        kind    = K_PIPE;
                        keep    = 1'b0;
                        consume = 1'b0;
                    end
                end
                LX_GT:
                begin
                    if (!eof && c == "&")
                        nxt = LX_GT_AMP;
                    else if (!eof && c == ">")
                    begin
                        done = 1'b1;
                        kind = K_APPEND;
                    end
                    else
                    begin
                        done    = 1'b1;
                        kind    = K_OUT;
                        keep    = 1'b0;
                        consume = 1'b0;
                    end
                end
                default:
                begin
                    if (eof)
                    begin
                        keep = 1'b0;
                        done = 1'b1;
                        kind = K_ENDFILE;
                    end
                    else if (c != 8'h0a && is_blank(c))
                        keep = 1'b0;
                    else if (is_digit_char(c))
                        nxt = LX_DIGIT;
                    else if (c == 8'h00 || c == 8'h0a)
                    begin
                        done = 1'b1;
                        kind = K_NEWLINE;
                    end
                    else if (c == ";")
                    begin
                        done = 1'b1;
                        kind = K_SEMI;
                    end
                    else if (c == "\"")
                    begin
                        keep = 1'b0;
                        nxt  = LX_STRING;
                    end
                    else if (c == "#")
                    begin
                        keep = 1'b0;
                        nxt  = LX_COMMENT;
                    end
                    else if (c == "&")
                        nxt = LX_AMP;
                    else if (c == "|")
                        nxt = LX_BAR;
                    else if (c == "<")
                    begin
                        done = 1'b1;
                        kind = K_IN;
                    end
                    else if (c == "!")
                    begin
                        done = 1'b1;
                        kind = K_NOT;
                    end
                    else if (c == ">")
                        nxt = LX_GT;
                    else if (c == "(")
                    begin
                        done = 1'b1;
                        kind = K_LPAREN;
                    end
                    else if (c == ")")
                    begin
                        done = 1'b1;
                        kind = K_RPAREN;
                    end
                    else if (is_forbidden(c))
                        err = E_FORBIDDEN;
                    else
                        nxt = LX_WORD;
                end
            endcase

            // errors drop the character and restart the lexer
            if (err != E_NONE)
            begin
                keep          = 1'b0;
                done          = 1'b0;
                kind          = K_ENDFILE;
                consume       = 1'b1;
                lex_state     = LX_START;
                word_nonempty = 1'b0;
            end
            else if (done)
            begin
                lex_state     = LX_START;
                word_nonempty = 1'b0;
            end
            else
            begin
                lex_state = nxt;
                if (keep)
                    word_nonempty = 1'b1;
            end

            fin          = consume || n == 2;
            r.keep_char  = keep;
            r.text_char  = c;
            r.token_done = done;
            r.token_kind = kind;
            r.error_code = err;
            r.last       = fin;
            expected_passes = {expected_passes, r};
            n++;
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic check_pass();
        result_t want;
        if (expected_passes.size() == 0)
        begin
            $display("%0t: unexpected result keep=%0d char=%h done=%0d kind=%0d err=%0d last=%0d",
                     $time, keep_char, text_char, token_done, token_kind, error_code, last);
            mismatch_count++;
        end
        else
        begin
            want = expected_passes.pop_front();
            check_field("keep_char", 8'(want.keep_char), 8'(keep_char));
            check_field("text_char", want.text_char, text_char);
            check_field("token_done", 8'(want.token_done), 8'(token_done));
            check_field("token_kind", 8'(want.token_kind), 8'(token_kind));
            check_field("error_code", 8'(want.error_code), 8'(error_code));
            check_field("last", 8'(want.last), 8'(last));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_pass();
            if (push && !full)
                lex_one_input(ch, end_of_input);
            passes_outstanding = expected_passes.size();
        end
    end

endmodule

FILE: test/tb_shell_token_lexer.sv
module tb_shell_token_lexer;
    import stl_pkg::*;

    // cycles without any transfer before the run is declared hung
    localparam int IDLE_LIMIT  = 2000;
    // long receiver hold-off that backs the block up into its input queue
    localparam int HOLD_CYCLES = 80;
    // random characters after the directed part
    localparam int RANDOM_ITEMS = 64;
    // sent_count window in which neither side idles
    localparam int STEADY_FROM = 60;
    localparam int STEADY_TO   = 80;
    // sent_count at which the long hold-off starts
    localparam int HOLD_AT     = 50;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       push         = 1'b0;
    logic [7:0] ch           = 8'h00;
    logic       end_of_input = 1'b0;
    logic       pop          = 1'b0;

    logic       full;
    logic       empty;
    logic       keep_char;
    logic [7:0] text_char;
    logic       token_done;
    logic [4:0] token_kind;
    logic [2:0] error_code;
    logic       last;

    int mismatch_count;
    int passes_outstanding;

    // character stream to send, bit 8 marks end of input
    logic [8:0] char_stream[$];
    int         sent_count  = 0;
    int         idle_cycles = 0;

    shell_token_lexer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .ch           (ch),
        .end_of_input (end_of_input),
        .empty        (empty),
        .pop          (pop),
        .keep_char    (keep_char),
        .text_char    (text_char),
        .token_done   (token_done),
        .token_kind   (token_kind),
        .error_code   (error_code),
        .last         (last)
    );

    // watches both channels, predicts every pass and counts mismatches
    token_lexer_checker u_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .ch                 (ch),
        .end_of_input       (end_of_input),
        .empty              (empty),
        .pop                (pop),
        .keep_char          (keep_char),
        .text_char          (text_char),
        .token_done         (token_done),
        .token_kind         (token_kind),
        .error_code         (error_code),
        .last               (last),
        .mismatch_count     (mismatch_count),
        .passes_outstanding (passes_outstanding)
    );

    always #10 clk = ~clk;

    // hang detection: any transfer on either side restarts the count
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic add_char(input logic [7:0] c);
        logic [8:0] entry;
        entry       = {1'b0, c};
        char_stream = {char_stream, entry};
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    // the byte is ignored under end of input, so keep it random anyway
    task automatic add_eof();
        logic [8:0] entry;
        entry       = {1'b1, 8'($urandom_range(0, 255))};
        char_stream = {char_stream, entry};
    endtask

    // letters, digits inside words and high bytes all make plain command text
    function automatic logic [7:0] word_char();
        case ($urandom_range(0, 3))
            0:       return 8'($urandom_range("a", "z"));
            1:       return 8'($urandom_range("A", "Z"));
            2:       return 8'($urandom_range(8'h80, 8'hff));
            default: return 8'($urandom_range("0", "9"));
        endcase
    endfunction

    // printable bytes above the double quote, or high bytes
    function automatic logic [7:0] string_char();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(8'h80, 8'hff));
        else
            return 8'($urandom_range(8'h23, 8'h7e));
    endfunction

    task automatic add_operator();
        case ($urandom_range(0, 11))
            0:       add_text("|");
            1:       add_text("||");
            2:       add_text("&&");
            3:       add_text("&>");
            4:       add_text("&>>");
            5:       add_text("<");
            6:       add_text(">");
            7:       add_text(">>");
            8:       add_text("!");
            9:       add_text("(");
            10:      add_text(")");
            default: add_text(";");
        endcase
    endtask

    // one shell phrase; most are well formed, some are noise or broken
    task automatic add_random_phrase();
        int n;
        case ($urandom_range(0, 19))
            0, 1, 2, 3:
            begin
                n = $urandom_range(1, 5);
                repeat (n) add_char(word_char());
            end
            4:
            begin
                // digit-prefixed redirection, sometimes into another stream
                add_char(8'($urandom_range("0", "9")));
                case ($urandom_range(0, 2))
                    0:       add_text(">");
                    1:       add_text(">>");
                    default:
                    begin
                        add_text(">&");
                        n = $urandom_range(0, 2);
                        repeat (n) add_char(8'($urandom_range("0", "9")));
                    end
                endcase
            end
            5:
            begin
                add_text("\"");
                n = $urandom_range(0, 4);
                repeat (n) add_char(string_char());
                add_text("\"");
            end
            6:
            begin
                add_text("#");
                n = $urandom_range(0, 4);
                repeat (n) add_char(8'($urandom_range(8'h0b, 8'hff)));
                add_char(8'h0a);
            end
            7, 18, 19:
                add_operator();
            8, 9, 10:
            begin
                if ($urandom_range(0, 1) == 0)
                    add_text(" ");
                else
                    add_char(8'($urandom_range(8'h09, 8'h0d)));
            end
            11:
                add_char(8'h0a);
            12:
                add_eof();
            13, 14:
                add_char(8'($urandom_range(0, 255)));
            15:
            begin
                // string cut off by a newline
                add_text("\"");
                n = $urandom_range(0, 3);
                repeat (n) add_char(string_char());
                add_char(8'h0a);
            end
            16:
            begin
                add_text("&");
                add_char(8'($urandom_range(0, 255)));
            end
            default:
                add_char(8'h00);
        endcase
    endtask

    // sender: drives at the falling edge, a transfer completes at the
    // rising edge that sees push high and full low
    initial
    begin
        int         target;
        int         gap;
        logic [8:0] item;

        // directed part: nul as a newline token, digit falling into a word
        // and then a terminator (three passes), high byte word closed by a
        // paren, 2>&1 closed by ||, &&, &>>, !, | closed by ), <, >>,
        // > closed by a string, &> closed by a forbidden byte, comment,
        // then end of input after &, inside a string and inside a word
        add_char(8'h00);
        add_text("9;");
        add_char(8'hff);
        add_text("(2>&1||&&&>>!|)<>>>\"x\"&>:#\n&");
        add_eof();
        add_text("\"");
        add_eof();
        add_text("b");
        add_eof();

        target = char_stream.size() + RANDOM_ITEMS;
        while (char_stream.size() < target)
            add_random_phrase();

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (char_stream[i])
        begin
            item = char_stream[i];
            if (sent_count >= STEADY_FROM && sent_count < STEADY_TO)
                gap = 0;
            else
                gap = pick_gap();
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            push         <= 1'b1;
            ch           <= item[7:0];
            end_of_input <= item[8];
            // hold the character until the transfer happens
            @(posedge clk);
            while (full)
                @(posedge clk);
            sent_count++;
            @(negedge clk);
        end
        push <= 1'b0;

        // drain every predicted pass, then give the pipeline time to show
        // anything unexpected
        while (passes_outstanding != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // receiver: pop idles at random, and once holds off long enough for
    // the block to fill and stall the sender
    initial
    begin
        int hold;
        bit held_off;
        held_off = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held_off && sent_count >= HOLD_AT)
            begin
                hold     = HOLD_CYCLES;
                held_off = 1'b1;
            end
            else if (sent_count >= STEADY_FROM && sent_count < STEADY_TO)
                hold = 0;
            else
                hold = pick_gap();
            if (hold > 0)
            begin
                pop <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            pop <= 1'b1;
            @(negedge clk);
        end
    end

endmodule
